### hw/rtl/wsr_pkg.sv
// shared types and constants of the weighted sum ranking core
// field widths, register codes, controller states, command and status bundles
// no dependencies
package wsr_pkg;

	// defaults for the top level parameters
	localparam int MAX_ALTERNATIVES_DEF = 16;
	localparam int MAX_CRITERIA_DEF     = 16;
	localparam int VALUE_BITS_DEF       = 32;

	// fixed field widths
	localparam int KIND_W     = 1;
	localparam int ALT_IDX_W  = 4;
	localparam int CRIT_IDX_W = 4;
	localparam int VALUE_W    = 32;
	localparam int RANK_W     = 4;
	localparam int ALT_NUM_W  = 5;
	localparam int SCORE_W    = 64;

	// widened counts, wide enough for a maximum of 64
	localparam int CNT_EXT_W = 7;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 5;
	localparam logic [CFG_IDX_W-1:0]  REG_NUM_ALTERNATIVES = 1'd0;
	localparam logic [CFG_IDX_W-1:0]  REG_NUM_CRITERIA     = 1'd1;
	localparam logic [CFG_DATA_W-1:0] COUNT_RESET          = 5'd16;

	// load item kinds
	localparam logic [KIND_W-1:0] KIND_WEIGHT = 1'b0;
	localparam logic [KIND_W-1:0] KIND_ENTRY  = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SC_RD,
		ST_SC_MUL,
		ST_SC_ACC,
		ST_SORT_RI,
		ST_SORT_LI,
		ST_SORT_RJ,
		ST_SORT_CJ,
		ST_SORT_WI,
		ST_EMIT_RD,
		ST_EMIT_LD
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load_wr;
		logic mat_rd;
		logic mul;
		logic acc_en;
		logic acc_first;
		logic ss_wr_acc;
		logic ss_wr_cur;
		logic ss_rd;
		logic cur_ld;
		logic out_ld;
		logic out_last;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic cur_lt;
		logic out_free;
	} sts_t;

endpackage

### hw/rtl/wsr_if.sv
// channel interfaces of the weighted sum ranking core: load, result and config
// depends on wsr_pkg for field widths
interface wsr_load_if;
	logic                                 valid;
	logic                                 ready;
	logic [wsr_pkg::KIND_W-1:0]           kind;
	logic [wsr_pkg::ALT_IDX_W-1:0]        alt_index;
	logic [wsr_pkg::CRIT_IDX_W-1:0]       crit_index;
	logic signed [wsr_pkg::VALUE_W-1:0]   value;
	logic                                 start_ranking;

	modport source (output valid, kind, alt_index, crit_index, value, start_ranking,
		input ready);
	modport sink (input valid, kind, alt_index, crit_index, value, start_ranking,
		output ready);
endinterface

interface wsr_result_if;
	logic                                 valid;
	logic                                 ready;
	logic [wsr_pkg::RANK_W-1:0]           rank_position;
	logic [wsr_pkg::ALT_NUM_W-1:0]        alternative_number;
	logic signed [wsr_pkg::SCORE_W-1:0]   score;
	logic                                 last_of_run;

	modport source (output valid, rank_position, alternative_number, score, last_of_run,
		input ready);
	modport sink (input valid, rank_position, alternative_number, score, last_of_run,
		output ready);
endinterface

interface wsr_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [wsr_pkg::CFG_IDX_W-1:0]    index;
	logic [wsr_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### hw/rtl/weighted_sum_ranking_core.sv
// top level of the weighted sum ranking core
// depends on wsr_pkg, wsr_if (channel interfaces), wsr_ctrl and wsr_datapath
//
// channel   dir   payload                                                  transaction
// load      in    kind, alt_index, crit_index, value, start_ranking       one weight or entry
// result    out   rank_position, alternative_number, score, last_of_run   one ranked alternative
// cfg       in    index, data                                             one register write
//
// load is ready only while the sequencer is idle
// an item with start_ranking set is stored, then na = alternatives and nc = criteria in use
// run through the sequencer: multiply-accumulate (read, multiply, add per term),
// exchange sort on the one-port score store, then emission of the results, which
// waits while a result is held and result.ready is low
// no clearing pass after reset: weights carry per-entry valid bits cleared by arst_n
// the result register lets the next load transaction in while the last result still waits
module weighted_sum_ranking_core #(
	parameter int MAX_ALTERNATIVES = wsr_pkg::MAX_ALTERNATIVES_DEF,
	parameter int MAX_CRITERIA     = wsr_pkg::MAX_CRITERIA_DEF,
	parameter int VALUE_BITS       = wsr_pkg::VALUE_BITS_DEF
) (
	input logic            clk,
	input logic            arst_n,
	wsr_load_if.sink       load,
	wsr_result_if.source   result,
	wsr_cfg_if.sink        cfg
);
	localparam int ALT_W  = $clog2(MAX_ALTERNATIVES);
	localparam int CRIT_W = (MAX_CRITERIA > 1) ? $clog2(MAX_CRITERIA) : 1;

	wsr_pkg::cmd_t     cmd;
	wsr_pkg::sts_t     sts;
	logic [ALT_W-1:0]  ss_addr;
	logic [CRIT_W-1:0] crit_addr;

	// sequencer: config registers, loop counters, state machine
	wsr_ctrl #(
		.MAX_ALTERNATIVES (MAX_ALTERNATIVES),
		.MAX_CRITERIA     (MAX_CRITERIA)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg.valid),
		.cfg_index  (cfg.index),
		.cfg_data   (cfg.data),
		.cfg_ready  (cfg.ready),
		.load_valid (load.valid),
		.load_start (load.start_ranking),
		.load_ready (load.ready),
		.sts        (sts),
		.cmd        (cmd),
		.ss_addr    (ss_addr),
		.crit_addr  (crit_addr)
	);

	// stores, multiply-accumulate, sort register and result register
	wsr_datapath #(
		.MAX_ALTERNATIVES (MAX_ALTERNATIVES),
		.MAX_CRITERIA     (MAX_CRITERIA),
		.VALUE_BITS       (VALUE_BITS)
	) u_datapath (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.sts                (sts),
		.ss_addr            (ss_addr),
		.crit_addr          (crit_addr),
		.kind               (load.kind),
		.alt_index          (load.alt_index),
		.crit_index         (load.crit_index),
		.value              (load.value),
		.out_valid          (result.valid),
		.out_ready          (result.ready),
		.rank_position      (result.rank_position),
		.alternative_number (result.alternative_number),
		.score              (result.score),
		.last_of_run        (result.last_of_run)
	);

endmodule

### hw/rtl/wsr_datapath.sv
// datapath of the weighted sum ranking core: weight and matrix stores,
// multiply-accumulate, score store with sort register, result register
// depends on wsr_pkg
module wsr_datapath #(
	parameter int MAX_ALTERNATIVES = wsr_pkg::MAX_ALTERNATIVES_DEF,
	parameter int MAX_CRITERIA     = wsr_pkg::MAX_CRITERIA_DEF,
	parameter int VALUE_BITS       = wsr_pkg::VALUE_BITS_DEF,
	localparam int ALT_W  = $clog2(MAX_ALTERNATIVES),
	localparam int CRIT_W = (MAX_CRITERIA > 1) ? $clog2(MAX_CRITERIA) : 1
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  wsr_pkg::cmd_t                          cmd,
	output wsr_pkg::sts_t                          sts,
	input  logic [ALT_W-1:0]                       ss_addr,
	input  logic [CRIT_W-1:0]                      crit_addr,
	input  logic [wsr_pkg::KIND_W-1:0]             kind,
	input  logic [wsr_pkg::ALT_IDX_W-1:0]          alt_index,
	input  logic [wsr_pkg::CRIT_IDX_W-1:0]         crit_index,
	input  logic signed [wsr_pkg::VALUE_W-1:0]     value,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [wsr_pkg::RANK_W-1:0]             rank_position,
	output logic [wsr_pkg::ALT_NUM_W-1:0]          alternative_number,
	output logic signed [wsr_pkg::SCORE_W-1:0]     score,
	output logic                                   last_of_run
);
	localparam int MAT_DEPTH = MAX_ALTERNATIVES * (2 ** CRIT_W);
	localparam int SW        = wsr_pkg::SCORE_W;
	localparam int EW        = wsr_pkg::CNT_EXT_W;

	logic signed [VALUE_BITS-1:0] w_mem [MAX_CRITERIA];
	logic signed [VALUE_BITS-1:0] mat_mem [MAT_DEPTH];
	logic [MAX_CRITERIA-1:0]      w_vld_q;

	logic signed [SW-1:0] ss_score_mem [MAX_ALTERNATIVES];
	logic [ALT_W-1:0]     ss_order_mem [MAX_ALTERNATIVES];

	logic [EW-1:0]                alt_ext;
	logic [EW-1:0]                crit_ext;
	logic                         alt_ok;
	logic                         crit_ok;
	logic [ALT_W-1:0]             ld_alt;
	logic [CRIT_W-1:0]            ld_crit;
	logic signed [VALUE_BITS-1:0] ld_val;

	logic signed [VALUE_BITS-1:0]   m_rd_q;
	logic signed [VALUE_BITS-1:0]   w_rd_q;
	logic                           w_ok_q;
	logic signed [VALUE_BITS-1:0]   w_eff;
	logic signed [2*VALUE_BITS-1:0] prod_full;
	logic signed [SW-1:0]           prod_q;
	logic signed [SW-1:0]           acc_q;
	logic signed [SW-1:0]           acc_base;
	logic [SW:0]                    sum_ext;
	logic signed [SW-1:0]           sum_sat;

	logic signed [SW-1:0] rd_score_q;
	logic [ALT_W-1:0]     rd_order_q;
	logic signed [SW-1:0] cur_score_q;
	logic [ALT_W-1:0]     cur_order_q;

	logic                                 out_valid_q;
	logic [wsr_pkg::RANK_W-1:0]           rank_q;
	logic [wsr_pkg::ALT_NUM_W-1:0]        alt_num_q;
	logic signed [SW-1:0]                 score_q;
	logic                                 last_q;

	// load decode, indices at or above the maximum are dropped
	assign alt_ext  = {{(EW - wsr_pkg::ALT_IDX_W){1'b0}}, alt_index};
	assign crit_ext = {{(EW - wsr_pkg::CRIT_IDX_W){1'b0}}, crit_index};
	assign alt_ok   = alt_ext < EW'(MAX_ALTERNATIVES);
	assign crit_ok  = crit_ext < EW'(MAX_CRITERIA);
	assign ld_alt   = alt_ext[ALT_W-1:0];
	assign ld_crit  = crit_ext[CRIT_W-1:0];
	assign ld_val   = value[VALUE_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_vld_q <= '0;
		end else if (cmd.load_wr && kind == wsr_pkg::KIND_WEIGHT && crit_ok) begin
			w_vld_q[ld_crit] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_wr && kind == wsr_pkg::KIND_WEIGHT && crit_ok) begin
			w_mem[ld_crit] <= ld_val;
		end
		if (cmd.load_wr && kind == wsr_pkg::KIND_ENTRY && crit_ok && alt_ok) begin
			mat_mem[{ld_alt, ld_crit}] <= ld_val;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mat_rd) begin
			m_rd_q <= mat_mem[{ss_addr, crit_addr}];
			w_rd_q <= w_mem[crit_addr];
			w_ok_q <= w_vld_q[crit_addr];
		end
	end

	// weight never written reads as zero
	assign w_eff     = w_ok_q ? w_rd_q : '0;
	assign prod_full = m_rd_q * w_eff;

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_q <= SW'(prod_full);
		end
	end

	// saturating accumulate
	assign acc_base = cmd.acc_first ? '0 : acc_q;
	assign sum_ext  = {acc_base[SW-1], acc_base} + {prod_q[SW-1], prod_q};
	always_comb begin
		if (sum_ext[SW] != sum_ext[SW-1]) begin
			sum_sat = sum_ext[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
		end else begin
			sum_sat = sum_ext[SW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.acc_en) begin
			acc_q <= sum_sat;
		end
	end

	// score store
	always_ff @(posedge clk) begin
		if (cmd.ss_wr_acc) begin
			ss_score_mem[ss_addr] <= sum_sat;
			ss_order_mem[ss_addr] <= ss_addr;
		end else if (cmd.ss_wr_cur) begin
			ss_score_mem[ss_addr] <= cur_score_q;
			ss_order_mem[ss_addr] <= cur_order_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ss_rd) begin
			rd_score_q <= ss_score_mem[ss_addr];
			rd_order_q <= ss_order_mem[ss_addr];
		end
	end

	// sort register, holds the candidate for the current place
	always_ff @(posedge clk) begin
		if (cmd.cur_ld) begin
			cur_score_q <= rd_score_q;
			cur_order_q <= rd_order_q;
		end
	end

	assign sts.cur_lt   = cur_score_q < rd_score_q;
	assign sts.out_free = !out_valid_q || out_ready;

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_ld) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			rank_q    <= wsr_pkg::RANK_W'(ss_addr);
			alt_num_q <= wsr_pkg::ALT_NUM_W'((ALT_W + 1)'(rd_order_q) + (ALT_W + 1)'(1));
			score_q   <= rd_score_q;
			last_q    <= cmd.out_last;
		end
	end

	assign out_valid          = out_valid_q;
	assign rank_position      = rank_q;
	assign alternative_number = alt_num_q;
	assign score              = score_q;
	assign last_of_run        = last_q;

endmodule

### hw/rtl/wsr_ctrl.sv
// controller of the weighted sum ranking core: configuration registers,
// sequencer for scoring, exchange sort and result emission
// depends on wsr_pkg
module wsr_ctrl #(
	parameter int MAX_ALTERNATIVES = wsr_pkg::MAX_ALTERNATIVES_DEF,
	parameter int MAX_CRITERIA     = wsr_pkg::MAX_CRITERIA_DEF,
	localparam int ALT_W  = $clog2(MAX_ALTERNATIVES),
	localparam int CRIT_W = (MAX_CRITERIA > 1) ? $clog2(MAX_CRITERIA) : 1
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	input  logic [wsr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [wsr_pkg::CFG_DATA_W-1:0]     cfg_data,
	output logic                               cfg_ready,
	input  logic                               load_valid,
	input  logic                               load_start,
	output logic                               load_ready,
	input  wsr_pkg::sts_t                      sts,
	output wsr_pkg::cmd_t                      cmd,
	output logic [ALT_W-1:0]                   ss_addr,
	output logic [CRIT_W-1:0]                  crit_addr
);
	localparam int EW = wsr_pkg::CNT_EXT_W;

	wsr_pkg::state_t state_q;
	wsr_pkg::state_t state_d;

	logic [wsr_pkg::CFG_DATA_W-1:0] na_cfg_q;
	logic [wsr_pkg::CFG_DATA_W-1:0] nc_cfg_q;
	logic [EW-1:0]                  na_ext;
	logic [EW-1:0]                  nc_ext;
	logic [ALT_W-1:0]               alt_last;
	logic [CRIT_W-1:0]              crit_last;

	logic [ALT_W-1:0]  i_q;
	logic [ALT_W-1:0]  j_q;
	logic [CRIT_W-1:0] c_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			na_cfg_q <= wsr_pkg::COUNT_RESET;
			nc_cfg_q <= wsr_pkg::COUNT_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				wsr_pkg::REG_NUM_ALTERNATIVES: na_cfg_q <= cfg_data;
				wsr_pkg::REG_NUM_CRITERIA:     nc_cfg_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// counts clamped to 1..maximum
	always_comb begin
		if (na_cfg_q == '0) begin
			na_ext = EW'(1);
		end else if (EW'(na_cfg_q) > EW'(MAX_ALTERNATIVES)) begin
			na_ext = EW'(MAX_ALTERNATIVES);
		end else begin
			na_ext = EW'(na_cfg_q);
		end
		if (nc_cfg_q == '0) begin
			nc_ext = EW'(1);
		end else if (EW'(nc_cfg_q) > EW'(MAX_CRITERIA)) begin
			nc_ext = EW'(MAX_CRITERIA);
		end else begin
			nc_ext = EW'(nc_cfg_q);
		end
	end

	assign alt_last  = ALT_W'(na_ext - EW'(1));
	assign crit_last = CRIT_W'(nc_ext - EW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wsr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// loop counters: i is the row or sort place, j the compared place or rank, c the column
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0;
			j_q <= '0;
			c_q <= '0;
		end else begin
			case (state_q)
				wsr_pkg::ST_IDLE: begin
					if (load_valid && load_start) begin
						i_q <= '0;
						c_q <= '0;
					end
				end
				wsr_pkg::ST_SC_ACC: begin
					if (c_q == crit_last) begin
						c_q <= '0;
						i_q <= (i_q == alt_last) ? '0 : i_q + ALT_W'(1);
					end else begin
						c_q <= c_q + CRIT_W'(1);
					end
				end
				wsr_pkg::ST_SORT_RI: begin
					j_q <= (i_q == alt_last) ? '0 : i_q + ALT_W'(1);
				end
				wsr_pkg::ST_SORT_CJ: begin
					if (j_q != alt_last) begin
						j_q <= j_q + ALT_W'(1);
					end
				end
				wsr_pkg::ST_SORT_WI: begin
					i_q <= i_q + ALT_W'(1);
				end
				wsr_pkg::ST_EMIT_LD: begin
					if (sts.out_free) begin
						j_q <= j_q + ALT_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			wsr_pkg::ST_IDLE: begin
				if (load_valid && load_start) begin
					state_d = wsr_pkg::ST_SC_RD;
				end
			end
			wsr_pkg::ST_SC_RD:  state_d = wsr_pkg::ST_SC_MUL;
			wsr_pkg::ST_SC_MUL: state_d = wsr_pkg::ST_SC_ACC;
			wsr_pkg::ST_SC_ACC: begin
				if (c_q == crit_last && i_q == alt_last) begin
					state_d = wsr_pkg::ST_SORT_RI;
				end else begin
					state_d = wsr_pkg::ST_SC_RD;
				end
			end
			wsr_pkg::ST_SORT_RI: begin
				state_d = (i_q == alt_last) ? wsr_pkg::ST_EMIT_RD : wsr_pkg::ST_SORT_LI;
			end
			wsr_pkg::ST_SORT_LI: state_d = wsr_pkg::ST_SORT_RJ;
			wsr_pkg::ST_SORT_RJ: state_d = wsr_pkg::ST_SORT_CJ;
			wsr_pkg::ST_SORT_CJ: begin
				state_d = (j_q == alt_last) ? wsr_pkg::ST_SORT_WI : wsr_pkg::ST_SORT_RJ;
			end
			wsr_pkg::ST_SORT_WI: state_d = wsr_pkg::ST_SORT_RI;
			wsr_pkg::ST_EMIT_RD: state_d = wsr_pkg::ST_EMIT_LD;
			wsr_pkg::ST_EMIT_LD: begin
				if (sts.out_free) begin
					state_d = (j_q == alt_last) ? wsr_pkg::ST_IDLE : wsr_pkg::ST_EMIT_RD;
				end
			end
			default: state_d = wsr_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd        = '0;
		load_ready = (state_q == wsr_pkg::ST_IDLE);
		case (state_q)
			wsr_pkg::ST_IDLE:   cmd.load_wr = load_valid;
			wsr_pkg::ST_SC_RD:  cmd.mat_rd = 1'b1;
			wsr_pkg::ST_SC_MUL: cmd.mul = 1'b1;
			wsr_pkg::ST_SC_ACC: begin
				cmd.acc_en    = 1'b1;
				cmd.acc_first = (c_q == '0);
				cmd.ss_wr_acc = (c_q == crit_last);
			end
			wsr_pkg::ST_SORT_RI, wsr_pkg::ST_SORT_RJ, wsr_pkg::ST_EMIT_RD: begin
				cmd.ss_rd = 1'b1;
			end
			wsr_pkg::ST_SORT_LI: cmd.cur_ld = 1'b1;
			wsr_pkg::ST_SORT_CJ: begin
				// swap only on strictly less, a tie does not swap
				cmd.ss_wr_cur = sts.cur_lt;
				cmd.cur_ld    = sts.cur_lt;
			end
			wsr_pkg::ST_SORT_WI: cmd.ss_wr_cur = 1'b1;
			wsr_pkg::ST_EMIT_LD: begin
				cmd.out_ld   = sts.out_free;
				cmd.out_last = (j_q == alt_last);
			end
			default: ;
		endcase
	end

	always_comb begin
		if (state_q inside {wsr_pkg::ST_SORT_RJ, wsr_pkg::ST_SORT_CJ,
				wsr_pkg::ST_EMIT_RD, wsr_pkg::ST_EMIT_LD}) begin
			ss_addr = j_q;
		end else begin
			ss_addr = i_q;
		end
	end

	assign crit_addr = c_q;

`ifndef NO_ASSERTIONS
	a_out_ld_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_ld |-> sts.out_free)
		else $error("result register loaded while occupied");

	a_start_scores: assert property (@(posedge clk) disable iff (!arst_n)
		(load_valid && load_ready && load_start) |=> (state_q == wsr_pkg::ST_SC_RD))
		else $error("start item did not launch scoring");

	a_sort_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == wsr_pkg::ST_SORT_CJ) |-> (j_q > i_q))
		else $error("sort compares a place with itself or an earlier one");

	a_sc_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == wsr_pkg::ST_SC_ACC) |-> (c_q <= crit_last && i_q <= alt_last))
		else $error("scoring index beyond count in use");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_ld && cmd.out_last) |=> (state_q == wsr_pkg::ST_IDLE))
		else $error("sequencer kept running after final result");
`endif

endmodule
